// ===== rtl/sme_pkg.sv =====
`timescale 1ns / 1ps

package sme_pkg;

    localparam int STACK_DEPTH_DEF = 256;
    localparam int CNT_W_DEF       = $clog2(STACK_DEPTH_DEF + 1);

    localparam int WORD_W = 32;
    localparam int DATA_W = 30;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DATA_W-1:0] data_t;

    // primitive codes carried in the data field
    localparam data_t PRIM_HALT  = data_t'(0);
    localparam data_t PRIM_ADD   = data_t'(1);
    localparam data_t PRIM_SUB   = data_t'(2);
    localparam data_t PRIM_MUL   = data_t'(3);
    localparam data_t PRIM_DIV   = data_t'(4);
    localparam data_t PRIM_PRINT = data_t'(6);

    typedef logic [1:0] fault_t;
    localparam fault_t FAULT_NONE = 2'd0;
    localparam fault_t FAULT_OVF  = 2'd1;
    localparam fault_t FAULT_UNF  = 2'd2;
    localparam fault_t FAULT_DIV0 = 2'd3;

    // instruction class
    typedef logic [2:0] cls_t;
    localparam cls_t CLS_PUSH  = 3'd0;
    localparam cls_t CLS_HALT  = 3'd1;
    localparam cls_t CLS_BIN   = 3'd2;
    localparam cls_t CLS_PRINT = 3'd3;
    localparam cls_t CLS_NOP   = 3'd4;

    typedef struct packed {
        logic   ir_load;
        logic   push;
        logic   halt;
        logic   fault_set;
        fault_t fault_code;
        logic   print;
        logic   alu_load;
        logic   div_start;
        logic   div_load;
        logic   wb;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        logic run;
        cls_t cls;
        logic full;
        logic lt2;
        logic empty;
        logic is_div;
        logic b_zero;
        logic div_done;
    } sts_t;

endpackage

// ===== rtl/sme_chan_if.sv =====
`timescale 1ns / 1ps

interface sme_in_if;
    logic                valid;
    logic                ready;
    sme_pkg::word_t      instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

interface sme_out_if #(
    parameter int CNT_W = sme_pkg::CNT_W_DEF
);
    logic                valid;
    logic                ready;
    logic                print_valid;
    logic signed [31:0]  print_value;
    logic                halted;
    logic signed [31:0]  top_value;
    logic [CNT_W-1:0]    depth_now;
    sme_pkg::fault_t     fault;

    modport source (output valid, output print_valid, output print_value, output halted,
                    output top_value, output depth_now, output fault, input ready);
    modport sink   (input valid, input print_valid, input print_value, input halted,
                    input top_value, input depth_now, input fault, output ready);
endinterface

// ===== rtl/sme_div.sv =====
`timescale 1ns / 1ps

module sme_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  sme_pkg::word_t dividend,
    input  sme_pkg::word_t divisor,
    output logic           done,
    output sme_pkg::word_t quotient
);

    localparam int W   = sme_pkg::WORD_W;
    localparam int CW  = $clog2(W);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  r_reg, r_next;
    logic [W-1:0]  d_reg, d_next;
    logic          neg_reg, neg_next;

    logic [W:0]    rem_sh;
    logic [W:0]    diff;

    assign rem_sh = {r_reg, q_reg[W-1]};
    assign diff   = rem_sh - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(W - 1);
            q_next    = dividend[W-1] ? (W'(0) - dividend) : dividend;
            d_next    = divisor[W-1] ? (W'(0) - divisor) : divisor;
            r_next    = '0;
            neg_next  = dividend[W-1] ^ divisor[W-1];
        end
        else if (busy_reg)
        begin
            if (!diff[W])
            begin
                r_next = diff[W-1:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = rem_sh[W-1:0];
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        r_reg   <= r_next;
        d_reg   <= d_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? (W'(0) - q_reg) : q_reg;

endmodule

// ===== rtl/sme_datapath.sv =====
`timescale 1ns / 1ps

module sme_datapath #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF,
    parameter int CNT_W       = $clog2(STACK_DEPTH + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  sme_pkg::word_t      instr_word,
    input  sme_pkg::cmd_t       cmd,
    output sme_pkg::sts_t       sts,
    output logic                print_valid,
    output logic signed [31:0]  print_value,
    output logic                halted,
    output logic signed [31:0]  top_value,
    output logic [CNT_W-1:0]    depth_now,
    output sme_pkg::fault_t     fault
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    sme_pkg::word_t   mem [STACK_DEPTH];

    sme_pkg::word_t   ir_reg;
    logic [CNT_W-1:0] count_reg;
    logic             run_reg;
    sme_pkg::word_t   tos_reg;
    sme_pkg::word_t   res_reg;
    sme_pkg::word_t   rd_data_reg;
    sme_pkg::fault_t  fault_reg;
    logic             pv_reg;
    sme_pkg::word_t   pval_reg;

    logic             out_pv_reg;
    sme_pkg::word_t   out_pval_reg;
    logic             out_halted_reg;
    sme_pkg::word_t   out_top_reg;
    logic [CNT_W-1:0] out_depth_reg;
    sme_pkg::fault_t  out_fault_reg;

    sme_pkg::data_t   dat;
    sme_pkg::word_t   dat_ext;
    sme_pkg::word_t   push_val;
    sme_pkg::cls_t    cls;
    logic [CNT_W-1:0] nos_idx;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    sme_pkg::word_t   wr_data;
    logic             mem_we;
    sme_pkg::word_t   alu_res;
    logic             div_done;
    sme_pkg::word_t   quot;

    assign dat      = ir_reg[sme_pkg::DATA_W-1:0];
    assign dat_ext  = {2'b00, dat};
    assign push_val = ir_reg[31] ? (sme_pkg::word_t'(0) - dat_ext) : dat_ext;
    assign nos_idx  = count_reg - CNT_W'(2);
    assign rd_addr  = nos_idx[ADDR_W-1:0];

    always_comb
    begin
        if (ir_reg[30] == 1'b0)
            cls = sme_pkg::CLS_PUSH;
        else if (dat == sme_pkg::PRIM_HALT)
            cls = sme_pkg::CLS_HALT;
        else if (dat == sme_pkg::PRIM_ADD || dat == sme_pkg::PRIM_SUB ||
                 dat == sme_pkg::PRIM_MUL || dat == sme_pkg::PRIM_DIV)
            cls = sme_pkg::CLS_BIN;
        else if (dat == sme_pkg::PRIM_PRINT)
            cls = sme_pkg::CLS_PRINT;
        else
            cls = sme_pkg::CLS_NOP;
    end

    assign sts.cls      = cls;
    assign sts.run      = run_reg;
    assign sts.full     = (count_reg == CNT_W'(STACK_DEPTH));
    assign sts.lt2      = (count_reg < CNT_W'(2));
    assign sts.empty    = (count_reg == '0);
    assign sts.is_div   = (dat == sme_pkg::PRIM_DIV);
    assign sts.b_zero   = (tos_reg == '0);
    assign sts.div_done = div_done;

    always_comb
    begin
        case (dat)
            sme_pkg::PRIM_ADD: alu_res = rd_data_reg + tos_reg;
            sme_pkg::PRIM_SUB: alu_res = rd_data_reg - tos_reg;
            default:           alu_res = rd_data_reg * tos_reg;
        endcase
    end

    sme_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .done     (div_done),
        .quotient (quot)
    );

    assign mem_we  = cmd.push || cmd.wb;
    assign wr_addr = cmd.push ? count_reg[ADDR_W-1:0] : rd_addr;
    assign wr_data = cmd.push ? push_val : res_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b1;
        end
        else
        begin
            if (cmd.push)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.wb)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.halt)
                run_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ir_load)
        begin
            ir_reg    <= instr_word;
            fault_reg <= sme_pkg::FAULT_NONE;
            pv_reg    <= 1'b0;
            pval_reg  <= '0;
        end
        if (cmd.push)
            tos_reg <= push_val;
        else if (cmd.wb)
            tos_reg <= res_reg;
        if (cmd.fault_set)
            fault_reg <= cmd.fault_code;
        if (cmd.print)
        begin
            pv_reg   <= 1'b1;
            pval_reg <= tos_reg;
        end
        if (cmd.alu_load)
            res_reg <= alu_res;
        else if (cmd.div_load)
            res_reg <= quot;
        if (cmd.out_load)
        begin
            out_pv_reg     <= pv_reg;
            out_pval_reg   <= pval_reg;
            out_halted_reg <= !run_reg;
            out_top_reg    <= (count_reg != '0) ? tos_reg : '0;
            out_depth_reg  <= count_reg;
            out_fault_reg  <= fault_reg;
        end
    end

    assign print_valid = out_pv_reg;
    assign print_value = out_pval_reg;
    assign halted      = out_halted_reg;
    assign top_value   = out_top_reg;
    assign depth_now   = out_depth_reg;
    assign fault       = out_fault_reg;

endmodule

// ===== rtl/sme_ctrl.sv =====
`timescale 1ns / 1ps

module sme_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  sme_pkg::sts_t sts,
    output sme_pkg::cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ir_load = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                state_next = S_FIN;
                if (sts.run)
                begin
                    case (sts.cls)
                        sme_pkg::CLS_PUSH:
                        begin
                            if (sts.full)
                            begin
                                cmd.fault_set  = 1'b1;
                                cmd.fault_code = sme_pkg::FAULT_OVF;
                            end
                            else
                                cmd.push = 1'b1;
                        end
                        sme_pkg::CLS_HALT:
                            cmd.halt = 1'b1;
                        sme_pkg::CLS_BIN:
                        begin
                            if (sts.lt2)
                            begin
                                cmd.fault_set  = 1'b1;
                                cmd.fault_code = sme_pkg::FAULT_UNF;
                            end
                            else
                                state_next = S_EXEC;
                        end
                        sme_pkg::CLS_PRINT:
                        begin
                            if (sts.empty)
                            begin
                                cmd.fault_set  = 1'b1;
                                cmd.fault_code = sme_pkg::FAULT_UNF;
                            end
                            else
                                cmd.print = 1'b1;
                        end
                        default:
                            state_next = S_FIN;
                    endcase
                end
            end
            S_EXEC:
            begin
                if (!sts.is_div)
                begin
                    cmd.alu_load = 1'b1;
                    state_next   = S_WB;
                end
                else if (sts.b_zero)
                begin
                    cmd.fault_set  = 1'b1;
                    cmd.fault_code = sme_pkg::FAULT_DIV0;
                    state_next     = S_FIN;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (sts.div_done)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = S_WB;
                end
            end
            S_WB:
            begin
                cmd.wb     = 1'b1;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/stack_machine_executor_unit.sv =====
`timescale 1ns / 1ps

// Executes one 32-bit stack machine instruction per input item and returns one result item
// per instruction. Push, halt, print, no-op, overflow and underflow words go from decode
// straight to the output state; a divide by zero passes execute first; add, subtract and
// multiply pass execute and write back, as the second operand comes from a registered
// stack memory read; divide also waits for the one-bit-per-cycle divider. A new item is
// accepted once the previous one has reached the output register, which holds the result
// until it is taken; a held result stalls the next one in its final state.
module stack_machine_executor_unit #(
    parameter int STACK_DEPTH = sme_pkg::STACK_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    sme_in_if.sink     in_ch,
    sme_out_if.source  out_ch
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    sme_pkg::cmd_t cmd;
    sme_pkg::sts_t sts;

    sme_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    sme_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .CNT_W       (CNT_W)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_word  (in_ch.instr_word),
        .cmd         (cmd),
        .sts         (sts),
        .print_valid (out_ch.print_valid),
        .print_value (out_ch.print_value),
        .halted      (out_ch.halted),
        .top_value   (out_ch.top_value),
        .depth_now   (out_ch.depth_now),
        .fault       (out_ch.fault)
    );

endmodule

// ===== rtl/sme_chk.sv =====
`timescale 1ns / 1ps

module sme_chk #(
    parameter int CNT_W = sme_pkg::CNT_W_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic               print_valid,
    input logic signed [31:0] print_value,
    input logic               halted,
    input logic signed [31:0] top_value,
    input logic [CNT_W-1:0]   depth_now,
    input sme_pkg::fault_t    fault
);

    logic [1:0] pend_reg;
    logic       halt_seen_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= '0;
            halt_seen_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_reg + {1'b0, in_acc} - {1'b0, out_acc};
            if (out_acc && halted)
                halt_seen_reg <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(top_value) && $stable(depth_now))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 2'd0)
        else $error("result without an accepted item");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && halt_seen_reg |-> halted)
        else $error("halted flag dropped");

    a_print_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && print_valid |-> print_value == top_value && fault == sme_pkg::FAULT_NONE)
        else $error("print value mismatch");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && depth_now == '0 |-> top_value == '0 && !print_valid)
        else $error("empty stack shows a value");

endmodule

bind stack_machine_executor_unit sme_chk #(.CNT_W(CNT_W)) u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .print_valid (out_ch.print_valid),
    .print_value (out_ch.print_value),
    .halted      (out_ch.halted),
    .top_value   (out_ch.top_value),
    .depth_now   (out_ch.depth_now),
    .fault       (out_ch.fault)
);
